[rtl/prpg_pkg.sv]
// Shared constants, types and the arctangent table of the polar ring point generator.
package prpg_pkg;

    // Default sizing of the rotation unit.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    // Field widths.
    localparam int RADIUS_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int SPAN_W   = 18;
    localparam int CENTER_W = 16;
    localparam int COUNT_W  = 16;
    localparam int POINT_W  = 17;
    localparam int TRIG_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Rotation datapath: 32-bit angle in turns, Q2.30 vector components.
    localparam int ROT_W      = 32;
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = 5;
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Divider: magnitude of index * span fits 34 bits, two quotient bits per cycle.
    localparam int DIV_DVD_W = 34;
    localparam int DIV_STEPS = DIV_DVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ANGLE   = 3'd0,
        CFG_ANGLE_SPAN   = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_CLOSE_LOOP   = 3'd4,
        CFG_SAMPLE_COUNT = 3'd5
    } t_cfg_idx;

    // atan(2^-k) in units of 2^-32 turn.
    function automatic logic [ROT_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] k);
        logic [ROT_W-1:0] v;
        unique case (k)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/polar_ring_point_generator_core.sv]
// Top level of the polar ring point generator: sequencer, shared multiplier and output register.
//
// Each accepted radius word yields one ring point, x = cx + (r*cos(A) >>> 15) and
// y = cy + (r*sin(A) >>> 15), where (cx, cy) is the ring center and
// A = start + floor(index*sweep/count) in turns of 2^16, start being the base angle
// register and sweep the angle span register. The sample index advances per word, wrapping
// after sample_count words (a count of zero acts as one). The last word of a ring carries
// ring_end; with ring closing enabled it instead emits its point and then a copy of the
// ring's first point carrying ring_end. A word passes through these steps before the next
// word is accepted, waiting longer when a ring is closed and while the output register
// stays full: the shared 18x18 multiplier for index*sweep, the radix-4 divider, the
// rotation unit, two more multiplier passes for r*cos and r*sin, the last sum, the
// hand-off to the output register and the idle state that takes the next word. The
// input side stays ready while the last result waits in the output register, so the
// next word's work overlaps a stalled consumer. The configuration port is always ready;
// write it only while no word is in flight.
module polar_ring_point_generator_core #(
    parameter int CORDIC_STEPS = prpg_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = prpg_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // radius words in
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [prpg_pkg::RADIUS_W-1:0]  i_radius,
    // ring points out
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [prpg_pkg::POINT_W-1:0]   o_point_x,
    output logic signed [prpg_pkg::POINT_W-1:0]   o_point_y,
    output logic                                  o_ring_end,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [prpg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [prpg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int RW = prpg_pkg::RADIUS_W;
    localparam int AW = prpg_pkg::ANGLE_W;
    localparam int SW = prpg_pkg::SPAN_W;
    localparam int CW = prpg_pkg::CENTER_W;
    localparam int NW = prpg_pkg::COUNT_W;
    localparam int PW = prpg_pkg::POINT_W;
    localparam int TW = prpg_pkg::TRIG_W;
    localparam int MW = SW;            // multiplier operand width
    localparam int DW = prpg_pkg::DIV_DVD_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_DIVS  = 10'b0000000100,
        S_DIVW  = 10'b0000001000,
        S_ROTW  = 10'b0000010000,
        S_MX    = 10'b0000100000,
        S_MY    = 10'b0001000000,
        S_PY    = 10'b0010000000,
        S_EMIT1 = 10'b0100000000,
        S_EMIT2 = 10'b1000000000
    } t_state;

    // configuration registers
    logic [AW-1:0]        r_base;
    logic signed [SW-1:0] r_span;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic                 r_close;
    logic [NW-1:0]        r_count;

    // sequencer and datapath state
    t_state                 r_state, n_state;
    logic [NW-1:0]          r_idx;
    logic signed [RW-1:0]   r_radius;
    logic signed [2*MW-1:0] r_prod;
    logic signed [PW-1:0]   r_px, r_py;
    logic signed [PW-1:0]   r_first_x, r_first_y;

    // output register
    logic                 r_out_valid;
    logic signed [PW-1:0] r_out_x, r_out_y;
    logic                 r_out_end;

    logic                   in_fire;
    logic                   out_free;
    logic [NW-1:0]          cnt_eff;
    logic                   last;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic [2*MW-1:0]        prod_abs;
    logic                   div_start, div_done, div_rem_nz;
    logic [AW-1:0]          div_quot;
    logic [AW-1:0]          q16;
    logic [AW-1:0]          angle;
    logic                   rot_start, rot_done;
    logic signed [TW-1:0]   rot_cos, rot_sin;
    logic signed [PW-1:0]   sum_px, sum_py;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    // Output slot is free when empty or being drained this cycle.
    assign out_free    = !r_out_valid || i_out_ready;

    // Sample count of zero behaves as one; a lowered count ends the ring at once.
    assign cnt_eff = (r_count == '0) ? NW'(1) : r_count;
    assign last    = ({1'b0, r_idx} + (NW+1)'(1)) >= {1'b0, cnt_eff};

    // Shared multiplier: index*span, then r*cos, then r*sin.
    always_comb begin
        mul_a = {{(MW-NW){1'b0}}, r_idx};
        mul_b = r_span;
        unique case (r_state)
            S_MX: begin
                mul_a = {{(MW-RW){r_radius[RW-1]}}, r_radius};
                mul_b = {{(MW-TW){rot_cos[TW-1]}}, rot_cos};
            end
            S_MY: begin
                mul_a = {{(MW-RW){r_radius[RW-1]}}, r_radius};
                mul_b = {{(MW-TW){rot_sin[TW-1]}}, rot_sin};
            end
            default: begin
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Floor division of a signed product: divide the magnitude, then fix up the sign.
    assign prod_abs  = r_prod[2*MW-1] ? (2*MW)'(-r_prod) : r_prod;
    assign div_start = (r_state == S_DIVS);
    assign q16       = !r_prod[2*MW-1] ? div_quot :
                       (div_rem_nz ? ~div_quot : AW'(-div_quot));
    assign angle     = r_base + q16;
    assign rot_start = (r_state == S_DIVW) && div_done;

    // Products are Q15-scaled: floor shift by 15 is a bit slice of the 36-bit product.
    assign sum_px = PW'({r_cx[CW-1], r_cx} + r_prod[PW+14:15]);
    assign sum_py = PW'({r_cy[CW-1], r_cy} + r_prod[PW+14:15]);

    prpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_abs[DW-1:0]),
        .i_divisor  (cnt_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem_nz   (div_rem_nz)
    );

    prpg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_angle (angle),
        .o_done  (rot_done),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin)
    );

    // Sequencer: advance one phase per cycle, wait on the input, divider, rotator and output slot.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_MUL;
            S_MUL:   n_state = S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW:  if (div_done) n_state = S_ROTW;
            S_ROTW:  if (rot_done) n_state = S_MX;
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_PY;
            S_PY:    n_state = S_EMIT1;
            S_EMIT1: begin
                if (out_free) begin
                    n_state = (last && r_close) ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, sample index, output valid, configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_span      <= SW'(65536);
            r_cx        <= '0;
            r_cy        <= '0;
            r_close     <= 1'b1;
            r_count     <= NW'(64);
        end else begin
            r_state <= n_state;

            // Load a new word or drop the drained one.
            if ((r_state == S_EMIT1 || r_state == S_EMIT2) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Advance the index once the sample's point moves to the output register; wrap at ring end.
            if (r_state == S_EMIT1 && out_free) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (prpg_pkg::t_cfg_idx'(i_cfg_index))
                    prpg_pkg::CFG_BASE_ANGLE:   r_base  <= i_cfg_data[AW-1:0];
                    prpg_pkg::CFG_ANGLE_SPAN:   r_span  <= i_cfg_data[SW-1:0];
                    prpg_pkg::CFG_CENTER_X:     r_cx    <= i_cfg_data[CW-1:0];
                    prpg_pkg::CFG_CENTER_Y:     r_cy    <= i_cfg_data[CW-1:0];
                    prpg_pkg::CFG_CLOSE_LOOP:   r_close <= i_cfg_data[0];
                    prpg_pkg::CFG_SAMPLE_COUNT: r_count <= i_cfg_data[NW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_radius <= i_radius;
        end
        if (r_state == S_MUL || r_state == S_MX || r_state == S_MY) begin
            r_prod <= mul_p;
        end
        if (r_state == S_MY) begin
            r_px <= sum_px;
        end
        if (r_state == S_PY) begin
            r_py <= sum_py;
        end
        if (r_state == S_EMIT1 && out_free) begin
            r_out_x   <= r_px;
            r_out_y   <= r_py;
            r_out_end <= last && !r_close;
            // Hold the first point of the ring for closure.
            if (r_idx == '0) begin
                r_first_x <= r_px;
                r_first_y <= r_py;
            end
        end
        if (r_state == S_EMIT2 && out_free) begin
            r_out_x   <= r_first_x;
            r_out_y   <= r_first_y;
            r_out_end <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_ring_end  = r_out_end;

endmodule

[rtl/prpg_div.sv]
// Iterative unsigned divider, two quotient bits per cycle, for the angle step.
module prpg_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [prpg_pkg::DIV_DVD_W-1:0]  i_dividend,
    input  logic [prpg_pkg::COUNT_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [prpg_pkg::ANGLE_W-1:0]    o_quot,
    output logic                            o_rem_nz
);

    localparam int DW = prpg_pkg::DIV_DVD_W;
    localparam int CW = prpg_pkg::COUNT_W;
    localparam int NW = prpg_pkg::DIV_CNT_W;

    logic [DW-1:0] r_dvd;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_dvs;
    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [CW:0]   t1, t2;
    logic          ge1, ge2;
    logic [CW-1:0] rem1, rem2;

    // Two restoring steps per cycle.
    always_comb begin
        t1   = {r_rem, r_dvd[DW-1]};
        ge1  = (t1 >= {1'b0, r_dvs});
        rem1 = ge1 ? CW'(t1 - {1'b0, r_dvs}) : t1[CW-1:0];
        t2   = {rem1, r_dvd[DW-2]};
        ge2  = (t2 >= {1'b0, r_dvs});
        rem2 = ge2 ? CW'(t2 - {1'b0, r_dvs}) : t2[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == NW'(prpg_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-3:0], ge1, ge2};
            r_rem <= rem2;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_dvd[prpg_pkg::ANGLE_W-1:0];
    assign o_rem_nz = |r_rem;

endmodule

[rtl/prpg_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q1.15 cosine and sine.
module prpg_cordic #(
    parameter int CORDIC_STEPS = prpg_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = prpg_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [prpg_pkg::ANGLE_W-1:0]        i_angle,
    output logic                                o_done,
    output logic signed [prpg_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [prpg_pkg::TRIG_W-1:0]  o_sin
);

    localparam int RW = prpg_pkg::ROT_W;
    localparam int TW = prpg_pkg::TRIG_W;
    localparam int AW = prpg_pkg::ATAN_IDX_W;
    localparam int KW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [RW-1:0] KEEP = {RW{1'b1}} << (RW - ANGLE_BITS);

    logic signed [RW-1:0] r_x, r_y, r_z;
    logic                 r_flip;
    logic [KW-1:0]        r_k;
    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    logic signed [TW-1:0] r_cos, r_sin;

    logic [RW-1:0]        a32;
    logic                 flip;
    logic signed [RW-1:0] dx, dy, at;

    // Round to Q1.15 with saturation, negating first for the mirrored half-turn.
    function automatic logic signed [TW-1:0] to_q15(input logic signed [RW-1:0] v,
                                                    input logic neg);
        logic signed [RW+1:0] w;
        logic signed [RW-14:0] q;
        logic signed [TW-1:0] res;
        w = {{2{v[RW-1]}}, v};
        if (neg) begin
            w = -w;
        end
        w = w + (RW+2)'(16384);
        q = w[RW+1:15];
        if (q > (RW-13)'(32767)) begin
            res = 16'sh7FFF;
        end else if (q < -(RW-13)'(32768)) begin
            res = -16'sh8000;
        end else begin
            res = q[TW-1:0];
        end
        return res;
    endfunction

    always_comb begin
        a32  = {i_angle, {(RW - prpg_pkg::ANGLE_W){1'b0}}} & KEEP;
        flip = a32[RW-1] ^ a32[RW-2];
        dx   = r_y >>> r_k;
        dy   = r_x >>> r_k;
        at   = prpg_pkg::atan_turns(AW'(r_k));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= r_fin;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == KW'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // Fold the left half-plane onto the right; undo by negation at the end.
            r_x    <= prpg_pkg::CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= {a32[RW-1] ^ flip, a32[RW-2:0]};
            r_flip <= flip;
            r_k    <= '0;
        end else if (r_busy) begin
            if (!r_z[RW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_k <= r_k + 1'b1;
        end
        if (r_fin) begin
            r_cos <= to_q15(r_x, r_flip);
            r_sin <= to_q15(r_y, r_flip);
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

[bench/prpg_checker.sv]
`timescale 1ns / 100ps
// Ring point predictor and output comparator for the polar ring point generator.
module prpg_checker #(
    parameter int CORDIC_STEPS = prpg_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = prpg_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [prpg_pkg::RADIUS_W-1:0] i_radius,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [prpg_pkg::POINT_W-1:0]  i_point_x,
    input  logic signed [prpg_pkg::POINT_W-1:0]  i_point_y,
    input  logic                                 i_ring_end,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [prpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prpg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import prpg_pkg::*;

    localparam longint ROT_GAIN = 64'sd652032874;

    typedef struct packed {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic                      ring_end;
    } t_ring_point;

    // arctangent of 2^-k in units of 2^-32 turn
    logic [31:0] atan_steps [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    t_ring_point expected_points [$];
    int          fail_total = 0;

    logic        [ANGLE_W-1:0]  start_turn;
    logic signed [SPAN_W-1:0]   sweep;
    logic signed [CENTER_W-1:0] ctr_x;
    logic signed [CENTER_W-1:0] ctr_y;
    logic                       closing;
    logic        [COUNT_W-1:0]  sample_count;
    logic        [COUNT_W-1:0]  sample_index;
    logic signed [POINT_W-1:0]  first_x;
    logic signed [POINT_W-1:0]  first_y;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        fail_total++;
    endtask

    function automatic logic signed [TRIG_W-1:0] round_q15(input longint v);
        longint q;
        q = (v + 64'sd16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return TRIG_W'(q);
    endfunction

    task automatic cordic_sincos(input logic [ANGLE_W-1:0] angle,
                                 output logic signed [TRIG_W-1:0] cos_q15,
                                 output logic signed [TRIG_W-1:0] sin_q15);
        logic [31:0] turn;
        logic [31:0] shifted;
        logic        flip;
        longint      x, y, z, dx, dy;
        turn    = {angle, 16'h0000} & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
        shifted = turn + 32'h4000_0000;
        flip    = shifted[31];
        // fold the left half plane onto the right one and negate afterwards
        if (flip)
            turn = turn - 32'h8000_0000;
        z = longint'($signed(turn));
        x = ROT_GAIN;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_steps[k]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_steps[k]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q15 = round_q15(x);
        sin_q15 = round_q15(y);
    endtask

    task automatic predict_points(input logic signed [RADIUS_W-1:0] radius);
        longint                    count, prod, quot, px, py;
        logic signed [TRIG_W-1:0]  c, s;
        logic        [ANGLE_W-1:0] angle;
        logic                      ring_done;
        t_ring_point               pt;
        count = (sample_count == 0) ? 64'sd1 : longint'(sample_count);
        prod  = longint'(sample_index) * longint'(sweep);
        quot  = prod / count;
        // floor division for negative sweeps
        if (prod % count != 0 && prod < 0)
            quot = quot - 1;
        angle = ANGLE_W'(longint'(start_turn) + quot);
        cordic_sincos(angle, c, s);
        px = longint'(ctr_x) + ((longint'(radius) * longint'(c)) >>> 15);
        py = longint'(ctr_y) + ((longint'(radius) * longint'(s)) >>> 15);
        pt.x = POINT_W'(px);
        pt.y = POINT_W'(py);
        if (sample_index == 0) begin
            first_x = pt.x;
            first_y = pt.y;
        end
        ring_done   = (longint'(sample_index) + 1 >= count);
        pt.ring_end = ring_done && !closing;
        expected_points.push_back(pt);
        if (!ring_done) begin
            sample_index = sample_index + 1'b1;
        end else begin
            sample_index = '0;
            if (closing) begin
                pt.x        = first_x;
                pt.y        = first_y;
                pt.ring_end = 1'b1;
                expected_points.push_back(pt);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_ring_point want;
        if (!i_rst_n) begin
            start_turn   = '0;
            sweep        = SPAN_W'(65536);
            ctr_x        = '0;
            ctr_y        = '0;
            closing      = 1'b1;
            sample_count = COUNT_W'(64);
            sample_index = '0;
            first_x      = '0;
            first_y      = '0;
            expected_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BASE_ANGLE:   start_turn   = i_cfg_data[ANGLE_W-1:0];
                    CFG_ANGLE_SPAN:   sweep        = i_cfg_data[SPAN_W-1:0];
                    CFG_CENTER_X:     ctr_x        = i_cfg_data[CENTER_W-1:0];
                    CFG_CENTER_Y:     ctr_y        = i_cfg_data[CENTER_W-1:0];
                    CFG_CLOSE_LOOP:   closing      = i_cfg_data[0];
                    CFG_SAMPLE_COUNT: sample_count = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected point_x", i_point_x, 0);
                end else begin
                    want = expected_points.pop_front();
                    if (i_point_x !== want.x)
                        report_mismatch("point_x", i_point_x, $signed(want.x));
                    if (i_point_y !== want.y)
                        report_mismatch("point_y", i_point_y, $signed(want.y));
                    if (i_ring_end !== want.ring_end)
                        report_mismatch("ring_end", i_ring_end, want.ring_end);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_points(i_radius);
        end
        o_pending    <= expected_points.size();
        o_fail_count <= fail_total;
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the polar ring point generator bench: stimulus, handshake pacing and verdict.
module testbench;
    import prpg_pkg::*;

    localparam int TOTAL_WORDS  = 1020;  // directed words plus about a thousand random ones
    localparam int LONG_HOLD    = 400;   // receiver hold-off that backs the block up
    localparam int IDLE_LIMIT   = 5000;  // cycles without a handshake on any channel before giving up
    localparam int DRAIN_CYCLES = 100;   // quiet tail after the last point has drained

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic signed [RADIUS_W-1:0]  i_radius    = '0;
    logic                        i_out_ready = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data  = '0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [POINT_W-1:0]   o_point_x;
    logic signed [POINT_W-1:0]   o_point_y;
    logic                        o_ring_end;
    logic                        o_cfg_ready;

    int fail_count;
    int pending;
    int words_sent    = 0;
    int idle_cycles   = 0;
    bit steady        = 1'b0;   // no idling on either side while set
    bit long_hold_req = 1'b0;   // ask the receiver for one long hold-off

    polar_ring_point_generator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_radius    (i_radius),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_ring_end  (o_ring_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    prpg_checker point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_radius     (i_radius),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_point_x    (o_point_x),
        .i_point_y    (o_point_y),
        .i_ring_end   (o_ring_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly nothing or a few cycles, now and then a long gap.
    function automatic int idle_gap(input int min_len);
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            len = 0;
        else if (roll < 92)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(20, 80);
        return (len < min_len) ? min_len : len;
    endfunction

    // Radius: an extreme a fifth of the time, otherwise any 16-bit value.
    function automatic logic signed [RADIUS_W-1:0] pick_radius();
        case ($urandom_range(0, 9))
            0:       return RADIUS_W'(32767);
            1:       return RADIUS_W'(-32768);
            default: return RADIUS_W'($urandom);
        endcase
    endfunction

    // Offer one radius word, hold it until taken, then idle for a random gap.
    // Valid is dropped only when a gap follows, so back-to-back words keep it high.
    task automatic send_radius(input logic signed [RADIUS_W-1:0] radius);
        int gap;
        i_in_valid <= 1'b1;
        i_radius   <= radius;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        words_sent++;
        gap = steady ? 0 : idle_gap(0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write one register; the caller drops valid once after its last write.
    task automatic write_setting(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
    endtask

    // Drop the input valid and wait until every predicted point has come out.
    // Every word yields at least one point, so an empty store means the block is idle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    // Random settings for one phase; extremes come up often enough to matter.
    task automatic pick_settings(input bit write_all);
        int                         roll;
        bit                         wrote;
        logic signed [SPAN_W-1:0]   span;
        logic signed [CENTER_W-1:0] center;
        logic        [COUNT_W-1:0]  count;
        wrote = 1'b0;
        if (write_all || $urandom_range(0, 1)) begin
            write_setting(CFG_BASE_ANGLE, ($urandom_range(0, 3) == 0) ?
                          CFG_DATA_W'(65535 * $urandom_range(0, 1)) : CFG_DATA_W'($urandom));
            wrote = 1'b1;
        end
        if (write_all || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       span = SPAN_W'(-131072);
                1:       span = SPAN_W'(131071);
                2:       span = SPAN_W'(65536);
                3:       span = SPAN_W'(-65536);
                4:       span = '0;
                default: span = SPAN_W'($urandom);
            endcase
            write_setting(CFG_ANGLE_SPAN, CFG_DATA_W'(span));
            wrote = 1'b1;
        end
        if (write_all || $urandom_range(0, 1)) begin
            center = ($urandom_range(0, 3) == 0) ?
                     ($urandom_range(0, 1) ? CENTER_W'(32767) : CENTER_W'(-32768)) :
                     CENTER_W'($urandom);
            write_setting(CFG_CENTER_X, CFG_DATA_W'(center));
            wrote = 1'b1;
        end
        if (write_all || $urandom_range(0, 1)) begin
            center = ($urandom_range(0, 3) == 0) ?
                     ($urandom_range(0, 1) ? CENTER_W'(32767) : CENTER_W'(-32768)) :
                     CENTER_W'($urandom);
            write_setting(CFG_CENTER_Y, CFG_DATA_W'(center));
            wrote = 1'b1;
        end
        if (write_all || $urandom_range(0, 1)) begin
            write_setting(CFG_CLOSE_LOOP, CFG_DATA_W'($urandom_range(0, 1)));
            wrote = 1'b1;
        end
        if (write_all || !wrote || $urandom_range(0, 1)) begin
            // short rings mostly, so ring ends and closing points come often
            roll = $urandom_range(0, 99);
            if (roll < 55)
                count = COUNT_W'($urandom_range(1, 8));
            else if (roll < 85)
                count = COUNT_W'($urandom_range(9, 80));
            else if (roll < 93)
                count = COUNT_W'($urandom_range(0, 1));
            else if (roll < 97)
                count = COUNT_W'(64);
            else
                count = COUNT_W'(65535);
            write_setting(CFG_SAMPLE_COUNT, CFG_DATA_W'(count));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random ready runs, steady ready when asked, and one long hold-off
    // on request so the block backs up and stalls its input.
    initial begin : receiver
        bit level;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (steady) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                level = ($urandom_range(0, 3) != 0);
                i_out_ready <= level;
                if (level)
                    repeat ($urandom_range(1, 24)) @(posedge i_clk);
                else
                    repeat (idle_gap(1)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int words;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: steps of 1/64 turn around a 64-point ring, radius extremes.
        send_radius(RADIUS_W'(32767));
        send_radius(RADIUS_W'(-32768));
        send_radius(RADIUS_W'(0));
        send_radius(RADIUS_W'(-1));
        send_radius(RADIUS_W'(1));
        send_radius(RADIUS_W'(16384));

        // Lower the count below the current index: the next word closes the ring,
        // then a full four-point ring over the quadrant boundaries.
        wait_drained();
        write_setting(CFG_SAMPLE_COUNT, CFG_DATA_W'(4));
        i_cfg_valid <= 1'b0;
        repeat (5) send_radius(pick_radius());

        // Zero count acts as one: each word is its own open ring; extremes elsewhere.
        wait_drained();
        write_setting(CFG_BASE_ANGLE,   CFG_DATA_W'(65535));
        write_setting(CFG_ANGLE_SPAN,   CFG_DATA_W'(SPAN_W'(-131072)));
        write_setting(CFG_CENTER_X,     CFG_DATA_W'(CENTER_W'(32767)));
        write_setting(CFG_CENTER_Y,     CFG_DATA_W'(CENTER_W'(-32768)));
        write_setting(CFG_CLOSE_LOOP,   CFG_DATA_W'(0));
        write_setting(CFG_SAMPLE_COUNT, CFG_DATA_W'(0));
        i_cfg_valid <= 1'b0;
        send_radius(RADIUS_W'(-32768));
        send_radius(RADIUS_W'(32767));
        send_radius(RADIUS_W'(12345));

        // One-point closed rings: every word brings a copy of itself.
        wait_drained();
        write_setting(CFG_BASE_ANGLE,   CFG_DATA_W'(0));
        write_setting(CFG_ANGLE_SPAN,   CFG_DATA_W'(SPAN_W'(131071)));
        write_setting(CFG_CENTER_X,     CFG_DATA_W'(CENTER_W'(-32768)));
        write_setting(CFG_CENTER_Y,     CFG_DATA_W'(CENTER_W'(32767)));
        write_setting(CFG_CLOSE_LOOP,   CFG_DATA_W'(1));
        write_setting(CFG_SAMPLE_COUNT, CFG_DATA_W'(1));
        i_cfg_valid <= 1'b0;
        send_radius(RADIUS_W'(-32768));
        send_radius(RADIUS_W'(32767));

        // Largest count with no sweep, then cut it short to an open ring of two.
        wait_drained();
        write_setting(CFG_ANGLE_SPAN,   CFG_DATA_W'(0));
        write_setting(CFG_SAMPLE_COUNT, CFG_DATA_W'(65535));
        i_cfg_valid <= 1'b0;
        repeat (3) send_radius(pick_radius());
        wait_drained();
        write_setting(CFG_CLOSE_LOOP,   CFG_DATA_W'(0));
        write_setting(CFG_SAMPLE_COUNT, CFG_DATA_W'(2));
        i_cfg_valid <= 1'b0;
        repeat (3) send_radius(pick_radius());

        // Random phases: new settings between phases, random words within.
        phase = 0;
        while (words_sent < TOTAL_WORDS) begin
            wait_drained();
            steady = (phase % 5 == 3);
            pick_settings(phase == 0);
            if (phase == 2 || phase == 9)
                long_hold_req = 1'b1;
            words = $urandom_range(20, 120);
            repeat (words) send_radius(pick_radius());
            phase++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[polar_ring_point_generator_core.f]
rtl/prpg_pkg.sv
rtl/prpg_div.sv
rtl/prpg_cordic.sv
rtl/polar_ring_point_generator_core.sv
bench/prpg_checker.sv
bench/testbench.sv
